// ===== sv/slq_pkg.sv =====
// Shared types and constants of the seat limited level queue.
package slq_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int MAX_SEATS  = 16;
    localparam int ID_BITS    = 8;

    localparam int LVL_IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SLOT_W     = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
    localparam int SCAN_W     = (MAX_LEVELS > MAX_SEATS) ? MAX_LEVELS : MAX_SEATS;
    localparam int SCAN_IDX_W = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;

    // Fixed field widths of the ports.
    localparam int LEVEL_W    = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_LV_W   = 4;
    localparam int CFG_SEAT_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEATS  = 1'b1;

    // Request codes.
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_NO_SEAT   = 3'd1,
        ST_BAD_LEVEL = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_SERVED    = 3'd4
    } status_t;

    // Write and read controls of the slot store.
    typedef struct packed {
        logic               req_we;
        logic [SLOT_W-1:0]  req_addr;
        logic [ID_BITS-1:0] req_data;
        logic               nxt_we;
        logic [SLOT_W-1:0]  nxt_addr;
        logic [SLOT_W-1:0]  nxt_data;
        logic [SLOT_W-1:0]  rd_addr;
    } slot_ctl_t;

endpackage

// ===== sv/slq_slot_mem.sv =====
// Slot store: requester id and next-slot link of every seat, registered read.
module slq_slot_mem (
    input  logic                          clk,
    input  slq_pkg::slot_ctl_t            ctl,
    output logic [slq_pkg::ID_BITS-1:0]   rd_req,
    output logic [slq_pkg::SLOT_W-1:0]    rd_nxt
);

    logic [slq_pkg::ID_BITS-1:0] req_mem_reg [slq_pkg::MAX_SEATS];
    logic [slq_pkg::SLOT_W-1:0]  nxt_mem_reg [slq_pkg::MAX_SEATS];

    always_ff @(posedge clk)
    begin
        if (ctl.req_we)
        begin
            req_mem_reg[ctl.req_addr] <= ctl.req_data;
        end
        if (ctl.nxt_we)
        begin
            nxt_mem_reg[ctl.nxt_addr] <= ctl.nxt_data;
        end
        rd_req <= req_mem_reg[ctl.rd_addr];
        rd_nxt <= nxt_mem_reg[ctl.rd_addr];
    end

endmodule

// ===== sv/slq_first_set.sv =====
// Shared search unit: finds the lowest set bit of a vector.
module slq_first_set (
    input  logic [slq_pkg::SCAN_W-1:0]     vec,
    output logic                           found,
    output logic [slq_pkg::SCAN_IDX_W-1:0] idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = slq_pkg::SCAN_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                found = 1'b1;
                idx   = slq_pkg::SCAN_IDX_W'(i);
            end
        end
    end

endmodule

// ===== sv/seat_limited_level_queue_core.sv =====
// Seat limited multilevel priority queue, top level with its sequencer.
// An enqueue or empty dequeue word passes through S_ENQ or S_DEQ_FIND and then S_EMIT,
// a served dequeue word through S_DEQ_FIND, S_DEQ_POP and S_EMIT, before its result is
// registered. One word is in work at a time, so a new request word is taken only after
// the last one has left S_EMIT, which waits while the output register is still full.
// Reset clears all queues, marks every seat free and loads 8 levels and 16 seats.
module seat_limited_level_queue_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [slq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slq_pkg::CFG_SEAT_W-1:0]   cfg_data,
    // Request channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [slq_pkg::ID_BITS-1:0]      requester_id,
    input  logic [slq_pkg::LEVEL_W-1:0]      level,
    // Result channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [slq_pkg::STATUS_W-1:0]     status,
    output logic [slq_pkg::ID_BITS-1:0]      served_id,
    output logic [slq_pkg::LEVEL_W-1:0]      served_level,
    output logic [slq_pkg::CFG_SEAT_W-1:0]   seats_free
);

    // The sequencer walks one word through its steps. Enqueue: one step that
    // checks the seat count and level, searches the lowest free slot and links
    // it in. Dequeue: one step that searches the lowest non-empty level in use
    // and starts the slot store read at its head, then one step that unlinks it.
    // The result is then held in the output register until it is taken.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ_FIND,
        S_DEQ_POP,
        S_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [slq_pkg::MAX_LEVELS-1:0]      nonempty_reg, nonempty_next;
    logic [slq_pkg::MAX_SEATS-1:0]       free_map_reg, free_map_next;
    logic [slq_pkg::CFG_SEAT_W-1:0]      taken_reg, taken_next;
    logic [slq_pkg::CFG_LV_W-1:0]        levels_reg, levels_next;
    logic [slq_pkg::CFG_SEAT_W-1:0]      limit_reg, limit_next;
    logic                                out_valid_reg, out_valid_next;
    logic [slq_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [slq_pkg::ID_BITS-1:0]         served_id_reg, served_id_next;
    logic [slq_pkg::LEVEL_W-1:0]         served_level_reg, served_level_next;
    logic [slq_pkg::CFG_SEAT_W-1:0]      seats_free_reg, seats_free_next;

    // Payload registers: the word in work, the staged result and the level
    // pointers. The pointers are only read after they were written.
    logic [slq_pkg::ID_BITS-1:0]         id_reg;
    logic [slq_pkg::LEVEL_W-1:0]         lev_reg;
    slq_pkg::status_t                    res_status_reg, res_status_next;
    logic [slq_pkg::ID_BITS-1:0]         res_id_reg, res_id_next;
    logic [slq_pkg::LVL_IDX_W-1:0]       res_lev_reg, res_lev_next;
    logic [slq_pkg::LVL_IDX_W-1:0]       dlev_reg, dlev_next;
    logic [slq_pkg::SLOT_W-1:0]          hslot_reg, hslot_next;
    logic [slq_pkg::SLOT_W-1:0]          head_reg [slq_pkg::MAX_LEVELS];
    logic [slq_pkg::SLOT_W-1:0]          tail_reg [slq_pkg::MAX_LEVELS];

    logic                                head_we, tail_we;
    logic [slq_pkg::LVL_IDX_W-1:0]       head_wa, tail_wa;
    logic [slq_pkg::SLOT_W-1:0]          head_wd, tail_wd;

    logic [slq_pkg::CFG_LV_W-1:0]        eff_levels;
    logic [slq_pkg::CFG_SEAT_W-1:0]      eff_limit;
    logic [slq_pkg::CFG_SEAT_W-1:0]      free_now;
    logic [slq_pkg::MAX_LEVELS-1:0]      level_mask;
    logic [slq_pkg::LVL_IDX_W-1:0]       enq_lev;

    logic [slq_pkg::SCAN_W-1:0]          scan_vec;
    logic                                scan_found;
    logic [slq_pkg::SCAN_IDX_W-1:0]      scan_idx;
    logic [slq_pkg::SLOT_W-1:0]          scan_slot;
    logic [slq_pkg::LVL_IDX_W-1:0]       scan_lev;

    slq_pkg::slot_ctl_t                  slot_ctl;
    logic [slq_pkg::ID_BITS-1:0]         rd_req;
    logic [slq_pkg::SLOT_W-1:0]          rd_nxt;

    slq_first_set u_search (
        .vec   (scan_vec),
        .found (scan_found),
        .idx   (scan_idx)
    );

    slq_slot_mem u_slots (
        .clk    (clk),
        .ctl    (slot_ctl),
        .rd_req (rd_req),
        .rd_nxt (rd_nxt)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = served_id_reg;
    assign served_level = served_level_reg;
    assign seats_free   = seats_free_reg;

    // Register values above the built-in sizes act as those sizes.
    always_comb
    begin
        eff_levels = (levels_reg > slq_pkg::CFG_LV_W'(slq_pkg::MAX_LEVELS))
                   ? slq_pkg::CFG_LV_W'(slq_pkg::MAX_LEVELS) : levels_reg;
        eff_limit  = (limit_reg > slq_pkg::CFG_SEAT_W'(slq_pkg::MAX_SEATS))
                   ? slq_pkg::CFG_SEAT_W'(slq_pkg::MAX_SEATS) : limit_reg;
        free_now   = (taken_reg >= eff_limit) ? '0 : (eff_limit - taken_reg);
        for (int l = 0; l < slq_pkg::MAX_LEVELS; l++)
        begin
            level_mask[l] = (slq_pkg::CFG_LV_W'(l) < eff_levels);
        end
        enq_lev = slq_pkg::LVL_IDX_W'(lev_reg);
    end

    // The search unit looks for a free slot on enqueue and for the lowest
    // non-empty level in use on dequeue.
    always_comb
    begin
        scan_vec = '0;
        if (state_reg == S_ENQ)
        begin
            scan_vec[slq_pkg::MAX_SEATS-1:0] = free_map_reg;
        end
        else
        begin
            scan_vec[slq_pkg::MAX_LEVELS-1:0] = nonempty_reg & level_mask;
        end
        scan_slot = scan_idx[slq_pkg::SLOT_W-1:0];
        scan_lev  = scan_idx[slq_pkg::LVL_IDX_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        nonempty_next     = nonempty_reg;
        free_map_next     = free_map_reg;
        taken_next        = taken_reg;
        levels_next       = levels_reg;
        limit_next        = limit_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        served_id_next    = served_id_reg;
        served_level_next = served_level_reg;
        seats_free_next   = seats_free_reg;
        res_status_next   = res_status_reg;
        res_id_next       = res_id_reg;
        res_lev_next      = res_lev_reg;
        dlev_next         = dlev_reg;
        hslot_next        = hslot_reg;
        head_we           = 1'b0;
        head_wa           = enq_lev;
        head_wd           = scan_slot;
        tail_we           = 1'b0;
        tail_wa           = enq_lev;
        tail_wd           = scan_slot;
        slot_ctl          = '0;
        slot_ctl.req_addr = scan_slot;
        slot_ctl.req_data = id_reg;
        slot_ctl.nxt_addr = tail_reg[enq_lev];
        slot_ctl.nxt_data = scan_slot;
        slot_ctl.rd_addr  = head_reg[scan_lev];

        if (cfg_we)
        begin
            case (cfg_index)
                slq_pkg::CFG_LEVELS: levels_next = cfg_data[slq_pkg::CFG_LV_W-1:0];
                slq_pkg::CFG_SEATS:  limit_next  = cfg_data;
                default:             ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == slq_pkg::REQ_DEQ) ? S_DEQ_FIND : S_ENQ;
                end
            end
            S_ENQ:
            begin
                res_id_next  = '0;
                res_lev_next = '0;
                state_next   = S_EMIT;
                // The seat check comes before the level check.
                if (free_now == '0)
                begin
                    res_status_next = slq_pkg::ST_NO_SEAT;
                end
                else if ({1'b0, lev_reg} >= eff_levels)
                begin
                    res_status_next = slq_pkg::ST_BAD_LEVEL;
                end
                else if (!scan_found)
                begin
                    res_status_next = slq_pkg::ST_NO_SEAT;
                end
                else
                begin
                    res_status_next          = slq_pkg::ST_QUEUED;
                    free_map_next[scan_slot] = 1'b0;
                    slot_ctl.req_we          = 1'b1;
                    if (nonempty_reg[enq_lev])
                    begin
                        // Link the new slot behind the current tail.
                        slot_ctl.nxt_we = 1'b1;
                    end
                    else
                    begin
                        head_we                = 1'b1;
                        nonempty_next[enq_lev] = 1'b1;
                    end
                    tail_we    = 1'b1;
                    taken_next = taken_reg + 1'b1;
                end
            end
            S_DEQ_FIND:
            begin
                if (!scan_found)
                begin
                    res_status_next = slq_pkg::ST_EMPTY;
                    res_id_next     = '0;
                    res_lev_next    = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    // The slot store read of the head starts at this edge.
                    dlev_next  = scan_lev;
                    hslot_next = head_reg[scan_lev];
                    state_next = S_DEQ_POP;
                end
            end
            S_DEQ_POP:
            begin
                res_status_next = slq_pkg::ST_SERVED;
                res_id_next     = rd_req;
                res_lev_next    = dlev_reg;
                if (hslot_reg == tail_reg[dlev_reg])
                begin
                    nonempty_next[dlev_reg] = 1'b0;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wa = dlev_reg;
                    head_wd = rd_nxt;
                end
                free_map_next[hslot_reg] = 1'b1;
                if (taken_reg != '0)
                begin
                    taken_next = taken_reg - 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // The free seat count already reflects this word.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    served_id_next    = res_id_reg;
                    served_level_next = slq_pkg::LEVEL_W'(res_lev_reg);
                    seats_free_next   = free_now;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            nonempty_reg     <= '0;
            free_map_reg     <= '1;
            taken_reg        <= '0;
            levels_reg       <= slq_pkg::CFG_LV_W'(slq_pkg::MAX_LEVELS);
            limit_reg        <= slq_pkg::CFG_SEAT_W'(slq_pkg::MAX_SEATS);
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            served_id_reg    <= '0;
            served_level_reg <= '0;
            seats_free_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            nonempty_reg     <= nonempty_next;
            free_map_reg     <= free_map_next;
            taken_reg        <= taken_next;
            levels_reg       <= levels_next;
            limit_reg        <= limit_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            served_id_reg    <= served_id_next;
            served_level_reg <= served_level_next;
            seats_free_reg   <= seats_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            id_reg   <= requester_id;
            lev_reg  <= level;
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_lev_reg    <= res_lev_next;
        dlev_reg       <= dlev_next;
        hslot_reg      <= hslot_next;
        if (head_we)
        begin
            head_reg[head_wa] <= head_wd;
        end
        if (tail_we)
        begin
            tail_reg[tail_wa] <= tail_wd;
        end
    end

endmodule

// ===== tb/slq_scoreboard_pkg.sv =====
// Scoreboard class of the seat limited level queue testbench: predictor and result checks.
`timescale 1ns / 1ps

package slq_scoreboard_pkg;
    import slq_pkg::*;

    typedef struct {
        status_t               status;
        logic [ID_BITS-1:0]    served_id;
        logic [LEVEL_W-1:0]    served_level;
        logic [CFG_SEAT_W-1:0] seats_free;
    } queue_result_t;

    class level_queue_scoreboard;
        // Shadow copy of the queue: a linked list per level over a shared seat store.
        logic [ID_BITS-1:0]    seat_id    [MAX_SEATS];
        logic [SLOT_W-1:0]     seat_link  [MAX_SEATS];
        logic [SLOT_W-1:0]     first_seat [MAX_LEVELS];
        logic [SLOT_W-1:0]     last_seat  [MAX_LEVELS];
        logic [MAX_LEVELS-1:0] occupied_levels;
        logic [MAX_SEATS-1:0]  open_seats;
        int unsigned           taken;
        logic [CFG_LV_W-1:0]   level_count;
        logic [CFG_SEAT_W-1:0] chair_count;

        queue_result_t awaited[$];
        int unsigned   mismatches;
        int unsigned   n_queued;
        int unsigned   n_served;
        int unsigned   n_empty;
        int unsigned   n_rejected;

        function new();
            occupied_levels = '0;
            open_seats      = '1;
            taken           = 0;
            level_count     = 4'd8;
            chair_count     = 5'd16;
            mismatches      = 0;
            n_queued        = 0;
            n_served        = 0;
            n_empty         = 0;
            n_rejected      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_SEAT_W-1:0] value);
            if (idx == CFG_LEVELS)
                level_count = value[CFG_LV_W-1:0];
            else
                chair_count = value;
        endfunction

        function int unsigned usable_levels();
            return (level_count > MAX_LEVELS) ? MAX_LEVELS : level_count;
        endfunction

        function int unsigned free_chairs();
            int unsigned lim;
            lim = (chair_count > MAX_SEATS) ? MAX_SEATS : chair_count;
            return (taken >= lim) ? 0 : lim - taken;
        endfunction

        // Works out the result of one accepted request word and queues it.
        function void note_request(logic kind, logic [ID_BITS-1:0] id, logic [LEVEL_W-1:0] lv);
            queue_result_t r;
            int unsigned   s;
            int unsigned   l;
            logic [SLOT_W-1:0] h;
            bit            done;
            r.status       = ST_EMPTY;
            r.served_id    = '0;
            r.served_level = '0;
            done           = 1'b0;
            if (kind == REQ_ENQ) begin
                if (free_chairs() == 0)
                    r.status = ST_NO_SEAT;
                else if (lv >= usable_levels())
                    r.status = ST_BAD_LEVEL;
                else begin
                    s = 0;
                    while (s < MAX_SEATS && !open_seats[s])
                        s++;
                    if (s >= MAX_SEATS)
                        r.status = ST_NO_SEAT;
                    else begin
                        open_seats[s] = 1'b0;
                        seat_id[s]    = id;
                        if (occupied_levels[lv])
                            seat_link[last_seat[lv]] = SLOT_W'(s);
                        else begin
                            first_seat[lv]      = SLOT_W'(s);
                            occupied_levels[lv] = 1'b1;
                        end
                        last_seat[lv] = SLOT_W'(s);
                        taken++;
                        r.status = ST_QUEUED;
                    end
                end
            end
            else begin
                for (l = 0; l < usable_levels(); l++) begin
                    if (!done && occupied_levels[l]) begin
                        h              = first_seat[l];
                        r.served_id    = seat_id[h];
                        r.served_level = LEVEL_W'(l);
                        if (h == last_seat[l])
                            occupied_levels[l] = 1'b0;
                        else
                            first_seat[l] = seat_link[h];
                        open_seats[h] = 1'b1;
                        if (taken > 0)
                            taken--;
                        r.status = ST_SERVED;
                        done     = 1'b1;
                    end
                end
            end
            r.seats_free = CFG_SEAT_W'(free_chairs());
            case (r.status)
                ST_QUEUED: n_queued++;
                ST_SERVED: n_served++;
                ST_EMPTY:  n_empty++;
                default:   n_rejected++;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [ID_BITS-1:0] id,
                                   logic [LEVEL_W-1:0] lv, logic [CFG_SEAT_W-1:0] free);
            queue_result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual status %0d",
                         $time, st);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status) begin
                $display("%0t: status: expected %0d, actual %0d", $time, e.status, st);
                mismatches++;
            end
            if (id !== e.served_id) begin
                $display("%0t: served_id: expected %0d, actual %0d", $time, e.served_id, id);
                mismatches++;
            end
            if (lv !== e.served_level) begin
                $display("%0t: served_level: expected %0d, actual %0d",
                         $time, e.served_level, lv);
                mismatches++;
            end
            if (free !== e.seats_free) begin
                $display("%0t: seats_free: expected %0d, actual %0d",
                         $time, e.seats_free, free);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top level testbench of the seat limited level queue: stimulus, handshakes and run control.
`timescale 1ns / 1ps

module tb;
    import slq_pkg::*;
    import slq_scoreboard_pkg::*;

    // The slowest correct run is roughly 1150 words plus the long hold, so this
    // limit leaves a wide margin.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 113;
    localparam int LONG_HOLD       = 300;
    // Extra wait after the last expected result has been delivered.
    localparam int SETTLE          = 8;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_LEVELS;
    logic [CFG_SEAT_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  req_type     = REQ_ENQ;
    logic [ID_BITS-1:0]    requester_id = '0;
    logic [LEVEL_W-1:0]    level        = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [ID_BITS-1:0]    served_id;
    logic [LEVEL_W-1:0]    served_level;
    logic [CFG_SEAT_W-1:0] seats_free;

    level_queue_scoreboard board = new();

    int unsigned cycles        = 0;
    int unsigned stall_left    = 0;
    int unsigned settings_used = 0;
    bit          sender_gaps   = 1'b0;
    bit          sink_stalls   = 1'b1;
    bit          hold_request  = 1'b0;

    seat_limited_level_queue_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .requester_id (requester_id),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .served_id    (served_id),
        .served_level (served_level),
        .seats_free   (seats_free)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Result side. Values read here are the ones present just before the edge, so a
    // word counts as delivered when out_valid and out_ready were both high at it.
    // The next out_ready is then chosen: a long hold when the stimulus asks for one,
    // otherwise random stall bursts of random length, or always ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(status, served_id, served_level, seats_free);
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD - 1;
            out_ready   <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offers one request word and returns at the edge where it is taken. Valid stays
    // high into the next call unless that call opens an idle gap first.
    task automatic send_word(input logic kind, input logic [ID_BITS-1:0] id,
                             input logic [LEVEL_W-1:0] lv);
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        requester_id <= id;
        level        <= lv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(kind, id, lv);
    endtask

    // Stops offering words until every expected result has been delivered.
    task automatic drain_queue();
        in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes both registers on back to back cycles while the block is idle.
    task automatic apply_setting(input logic [CFG_SEAT_W-1:0] levels_word,
                                 input logic [CFG_SEAT_W-1:0] seats_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEVELS;
        cfg_data  <= levels_word;
        @(posedge clk);
        board.write_register(CFG_LEVELS, levels_word);
        cfg_index <= CFG_SEATS;
        cfg_data  <= seats_word;
        @(posedge clk);
        board.write_register(CFG_SEATS, seats_word);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        int unsigned           p;
        int unsigned           i;
        int unsigned           enq_pct;
        int unsigned           usable;
        bit                    calm;
        logic                  kind;
        logic [ID_BITS-1:0]    id;
        logic [LEVEL_W-1:0]    lv;
        logic [CFG_SEAT_W-1:0] levels_word;
        logic [CFG_SEAT_W-1:0] seats_word;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting of 8 levels and 16 seats. An empty pop comes first, then one
        // word at each level extreme with id extremes; lower levels must leave first
        // and two words at level 0 must keep their arrival order.
        send_word(REQ_DEQ, 8'hFF, 3'd7);
        send_word(REQ_ENQ, 8'h00, 3'd7);
        send_word(REQ_ENQ, 8'hFF, 3'd0);
        send_word(REQ_ENQ, 8'h55, 3'd3);
        send_word(REQ_ENQ, 8'hAA, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);

        // Two levels, two seats: a bad level while a seat is free, then a full queue
        // rejects for lack of a seat even when the level is also out of range.
        drain_queue();
        apply_setting(5'd2, 5'd2);
        send_word(REQ_ENQ, 8'h01, 3'd1);
        send_word(REQ_ENQ, 8'h02, 3'd2);
        send_word(REQ_ENQ, 8'h03, 3'd0);
        send_word(REQ_ENQ, 8'h04, 3'd1);
        send_word(REQ_ENQ, 8'h05, 3'd6);

        // Seat limit dropped below the two waiting words: no enqueue gets in, free
        // seats read zero, and the waiting words are still served.
        drain_queue();
        apply_setting(5'd2, 5'd1);
        send_word(REQ_ENQ, 8'h06, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);

        // No levels at all with an oversized seat limit, then a seat limit of zero.
        drain_queue();
        apply_setting(5'd0, 5'd31);
        send_word(REQ_ENQ, 8'h07, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        drain_queue();
        apply_setting(5'd8, 5'd0);
        send_word(REQ_ENQ, 8'h08, 3'd0);
        send_word(REQ_DEQ, 8'h00, 3'd0);

        // An oversized level count acts as 8. A word left at level 5 is hidden while
        // only 4 levels are in use and comes back once the count is raised again.
        drain_queue();
        apply_setting(5'd15, 5'd16);
        send_word(REQ_ENQ, 8'h80, 3'd5);
        drain_queue();
        apply_setting(5'd4, 5'd16);
        send_word(REQ_DEQ, 8'h00, 3'd0);
        drain_queue();
        apply_setting(5'd8, 5'd16);
        send_word(REQ_DEQ, 8'h00, 3'd0);

        // Random phases, each under its own setting. Most enqueue words use a level
        // that is in range, and the enqueue share varies so the queue both fills up
        // and runs dry. The last two phases run without any idling.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p >= RANDOM_PHASES - 2);
            case ($urandom_range(0, 9))
                0:       levels_word = 5'd0;
                1:       levels_word = 5'd1;
                2:       levels_word = 5'd15;
                3:       levels_word = 5'd8;
                4:       levels_word = CFG_SEAT_W'($urandom_range(16, 31));
                default: levels_word = CFG_SEAT_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       seats_word = 5'd0;
                1:       seats_word = 5'd31;
                2:       seats_word = 5'd16;
                3:       seats_word = 5'd1;
                4:       seats_word = CFG_SEAT_W'($urandom_range(17, 30));
                default: seats_word = CFG_SEAT_W'($urandom_range(2, 16));
            endcase
            if (p == 2 || calm) begin
                levels_word = CFG_SEAT_W'($urandom_range(2, 8));
                seats_word  = 5'd16;
            end

            // The sender pauses here until every expected result is in.
            drain_queue();
            apply_setting(levels_word, seats_word);
            usable      = (levels_word[CFG_LV_W-1:0] > MAX_LEVELS) ?
                          MAX_LEVELS : levels_word[CFG_LV_W-1:0];
            enq_pct     = $urandom_range(35, 70);
            sender_gaps = !calm && $urandom_range(0, 3) != 0;
            sink_stalls = !calm && $urandom_range(0, 3) != 0;

            // One phase holds the result side off for a long stretch while words keep
            // coming, so the block backs up and stops taking request words.
            if (p == 2) begin
                sender_gaps  = 1'b0;
                hold_request = 1'b1;
            end

            for (i = 0; i < WORDS_PER_PHASE; i++) begin
                kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                id   = ID_BITS'($urandom);
                if (usable != 0 && $urandom_range(0, 9) != 0)
                    lv = LEVEL_W'($urandom_range(0, usable - 1));
                else
                    lv = LEVEL_W'($urandom_range(0, 7));
                send_word(kind, id, lv);
            end
        end

        drain_queue();

        $display("Covered %0d request words under %0d register settings.",
                 board.n_queued + board.n_served + board.n_empty + board.n_rejected,
                 settings_used);
        $display("Results: %0d queued, %0d served, %0d empty pops, %0d rejected.",
                 board.n_queued, board.n_served, board.n_empty, board.n_rejected);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
